// File: rtl/bgff_pkg.sv
// bgff_pkg: shared types, opcodes and default sizes for the grid flood fill block
`default_nettype none

package bgff_pkg;

  // default geometry, handed to the top level parameters
  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 1024;
  localparam int LABEL_BITS_DEF  = 8;

  // width of the 8-bit payload fields
  localparam int FIELD_BITS = 8;

  // command opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;

  // one command word
  typedef struct packed {
    logic [1:0]            opcode;
    logic [5:0]            cell_x;
    logic [5:0]            cell_y;
    logic [FIELD_BITS-1:0] write_value;
    logic [FIELD_BITS-1:0] region_label;
    logic [FIELD_BITS-1:0] fill_budget;
  } bgff_cmd_t;

  // one result word
  typedef struct packed {
    logic [FIELD_BITS-1:0] read_value;
    logic [FIELD_BITS-1:0] cells_filled;
    logic                  queue_overflow;
  } bgff_result_t;

  // controller to work queue
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } bgff_qcmd_t;

  // work queue to controller
  typedef struct packed {
    logic empty;
    logic full;
  } bgff_qstat_t;

endpackage

`default_nettype wire

// File: rtl/bgff_cell_ram.sv
// bgff_cell_ram: cell label memory, one write port and one registered read port
`default_nettype none

module bgff_cell_ram
  import bgff_pkg::*;
#(
  parameter int DEPTH     = GRID_WIDTH_DEF * GRID_HEIGHT_DEF,
  parameter int DATA_BITS = LABEL_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_BITS-1:0]     wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_BITS-1:0]     rdata
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/bgff_queue.sv
// bgff_queue: circular work queue of cell coordinates with registered pop data
`default_nettype none

module bgff_queue
  import bgff_pkg::*;
#(
  parameter int DEPTH     = QUEUE_DEPTH_DEF,
  parameter int DATA_BITS = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bgff_qcmd_t           cmd,
  input  wire logic [DATA_BITS-1:0] wdata,
  output logic      [DATA_BITS-1:0] rdata,
  output bgff_qstat_t               stat
);

  localparam int PB = $clog2(DEPTH);
  localparam int CB = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [PB-1:0]        head;
  logic [PB-1:0]        tail;
  logic [CB-1:0]        count;
  logic [PB-1:0]        wptr;
  logic                 wr_en;

  function automatic logic [PB-1:0] ptr_inc(input logic [PB-1:0] p);
    ptr_inc = (p == PB'(DEPTH - 1)) ? '0 : p + PB'(1);
  endfunction

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CB'(DEPTH));
  // a clear restarts the ring, so a push in the same cycle lands in entry zero
  assign wptr  = cmd.clear ? '0 : tail;
  assign wr_en = cmd.push && (cmd.clear || !stat.full);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wdata;
    end
    if (cmd.pop) begin
      rdata <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.clear) begin
      head  <= '0;
      tail  <= wr_en ? PB'(1) : '0;
      count <= wr_en ? CB'(1) : '0;
    end else begin
      if (cmd.pop) begin
        head <= ptr_inc(head);
      end
      if (wr_en) begin
        tail <= ptr_inc(tail);
      end
      if (wr_en && !cmd.pop) begin
        count <= count + CB'(1);
      end else if (!wr_en && cmd.pop) begin
        count <= count - CB'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CB'(DEPTH))
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && !stat.full && !cmd.clear && !cmd.pop) |=> count == $past(count) + CB'(1))
    else $error("accepted push did not grow the queue");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop && !cmd.push && !cmd.clear) |=> count == $past(count) - CB'(1))
    else $error("pop did not shrink the queue");

endmodule

`default_nettype wire

// File: rtl/bgff_ctrl.sv
// bgff_ctrl: command sequencer, memory clearing sweep and breadth-first fill engine
`default_nettype none

module bgff_ctrl
  import bgff_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  parameter int LABEL_BITS  = LABEL_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire bgff_cmd_t    cmd,
  output logic              busy,
  output logic              done,
  output bgff_result_t      result,
  output logic              map_we,
  output logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0] map_waddr,
  output logic [LABEL_BITS-1:0]                     map_wdata,
  output logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0] map_raddr,
  input  wire logic [LABEL_BITS-1:0]                map_rdata,
  output bgff_qcmd_t        q_cmd,
  output logic [$clog2(GRID_WIDTH)+$clog2(GRID_HEIGHT)-1:0] q_wdata,
  input  wire logic [$clog2(GRID_WIDTH)+$clog2(GRID_HEIGHT)-1:0] q_rdata,
  input  wire bgff_qstat_t  q_stat
);

  localparam int XB    = $clog2(GRID_WIDTH);
  localparam int YB    = $clog2(GRID_HEIGHT);
  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AB    = $clog2(CELLS);
  localparam int QW    = XB + YB;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_POP,
    S_POPWAIT,
    S_CHECK,
    S_NB,
    S_NBLAST
  } state_t;

  state_t                state;
  logic [AB-1:0]         clr_addr;
  logic                  rd_inside;
  logic [XB-1:0]         cur_x;
  logic [YB-1:0]         cur_y;
  logic [LABEL_BITS-1:0] label;
  logic [FIELD_BITS-1:0] budget;
  logic [FIELD_BITS-1:0] budget_left;
  logic                  ovf;
  logic [1:0]            nb_k;
  logic                  pend_v;
  logic [XB-1:0]         pend_x;
  logic [YB-1:0]         pend_y;

  logic                  on_grid;
  logic [XB-1:0]         in_x;
  logic [YB-1:0]         in_y;
  logic [XB-1:0]         q_x;
  logic [YB-1:0]         q_y;
  logic [LABEL_BITS-1:0] wr_label;
  logic [LABEL_BITS-1:0] fill_label;
  logic [FIELD_BITS-1:0] rd_byte;
  logic                  nb_ok;
  logic [XB-1:0]         nb_x;
  logic [YB-1:0]         nb_y;
  logic                  fill_end;

  function automatic logic [AB-1:0] cell_addr(input logic [XB-1:0] x,
                                              input logic [YB-1:0] y);
    cell_addr = AB'(AB'(y) * AB'(GRID_WIDTH) + AB'(x));
  endfunction

  assign on_grid = (32'(cmd.cell_x) < 32'(GRID_WIDTH)) &&
                   (32'(cmd.cell_y) < 32'(GRID_HEIGHT));
  assign in_x   = XB'(cmd.cell_x);
  assign in_y   = YB'(cmd.cell_y);
  assign q_x    = q_rdata[XB-1:0];
  assign q_y    = q_rdata[QW-1:XB];
  assign fill_end = q_stat.empty || (budget_left == '0);

  // labels fit to LABEL_BITS, read data cut or padded to the 8-bit field
  always_comb begin
    for (int i = 0; i < LABEL_BITS; i++) begin
      wr_label[i]   = (i < FIELD_BITS) ? cmd.write_value[i] : 1'b0;
      fill_label[i] = (i < FIELD_BITS) ? cmd.region_label[i] : 1'b0;
    end
    for (int i = 0; i < FIELD_BITS; i++) begin
      rd_byte[i] = (i < LABEL_BITS) ? map_rdata[i] : 1'b0;
    end
  end

  // neighbour order: right, left, down, up
  always_comb begin
    nb_ok = 1'b0;
    nb_x  = cur_x;
    nb_y  = cur_y;
    unique case (nb_k)
      2'd0: begin
        nb_ok = (cur_x != XB'(GRID_WIDTH - 1));
        nb_x  = cur_x + XB'(1);
      end
      2'd1: begin
        nb_ok = (cur_x != '0);
        nb_x  = cur_x - XB'(1);
      end
      2'd2: begin
        nb_ok = (cur_y != YB'(GRID_HEIGHT - 1));
        nb_y  = cur_y + YB'(1);
      end
      2'd3: begin
        nb_ok = (cur_y != '0);
        nb_y  = cur_y - YB'(1);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    busy      = (state != S_IDLE);
    map_we    = 1'b0;
    map_waddr = cell_addr(in_x, in_y);
    map_wdata = wr_label;
    map_raddr = cell_addr(in_x, in_y);
    q_cmd     = '0;
    q_wdata   = {in_y, in_x};
    unique case (state)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_addr;
        map_wdata = '0;
      end
      S_IDLE: begin
        if (start && on_grid && cmd.opcode == OP_WRITE) begin
          map_we = 1'b1;
        end
        if (start && on_grid && cmd.opcode == OP_FILL) begin
          q_cmd.clear = 1'b1;
          q_cmd.push  = 1'b1;
        end
      end
      S_READ: begin
      end
      S_POP: begin
        q_cmd.pop = !fill_end;
      end
      S_POPWAIT: begin
        map_raddr = cell_addr(q_x, q_y);
      end
      S_CHECK: begin
        map_waddr = cell_addr(cur_x, cur_y);
        map_wdata = label;
        map_we    = (map_rdata == '0);
      end
      S_NB, S_NBLAST: begin
        map_raddr  = cell_addr(nb_x, nb_y);
        q_wdata    = {pend_y, pend_x};
        q_cmd.push = pend_v && (map_rdata == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      done        <= 1'b0;
      budget_left <= '0;
      ovf         <= 1'b0;
      nb_k        <= '0;
      pend_v      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AB'(1);
          if (clr_addr == AB'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            unique case (cmd.opcode)
              OP_READ: begin
                rd_inside <= on_grid;
                state     <= S_READ;
              end
              OP_FILL: begin
                if (on_grid) begin
                  label       <= fill_label;
                  budget      <= cmd.fill_budget;
                  budget_left <= cmd.fill_budget;
                  ovf         <= 1'b0;
                  state       <= S_POP;
                end else begin
                  done   <= 1'b1;
                  result <= '0;
                end
              end
              default: begin
                done   <= 1'b1;
                result <= '0;
              end
            endcase
          end
        end
        S_READ: begin
          done                  <= 1'b1;
          result.read_value     <= rd_inside ? rd_byte : '0;
          result.cells_filled   <= '0;
          result.queue_overflow <= 1'b0;
          state                 <= S_IDLE;
        end
        S_POP: begin
          if (fill_end) begin
            done                  <= 1'b1;
            result.read_value     <= '0;
            result.cells_filled   <= budget - budget_left;
            result.queue_overflow <= ovf;
            state                 <= S_IDLE;
          end else begin
            state <= S_POPWAIT;
          end
        end
        S_POPWAIT: begin
          cur_x <= q_x;
          cur_y <= q_y;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (map_rdata != '0) begin
            state <= S_POP;
          end else begin
            nb_k   <= '0;
            pend_v <= 1'b0;
            state  <= S_NB;
          end
        end
        S_NB: begin
          if (q_cmd.push && q_stat.full) begin
            ovf <= 1'b1;
          end
          pend_v <= nb_ok;
          pend_x <= nb_x;
          pend_y <= nb_y;
          nb_k   <= nb_k + 2'd1;
          if (nb_k == 2'd3) begin
            state <= S_NBLAST;
          end
        end
        S_NBLAST: begin
          if (q_cmd.push && q_stat.full) begin
            ovf <= 1'b1;
          end
          pend_v      <= 1'b0;
          budget_left <= budget_left - FIELD_BITS'(1);
          state       <= S_POP;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_cmd.pop |-> !q_stat.empty)
    else $error("pop from empty work queue");

  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(q_cmd.push && q_cmd.pop))
    else $error("push and pop in one cycle");

  a_paint_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_NBLAST) |=> budget_left == $past(budget_left) - FIELD_BITS'(1))
    else $error("budget not charged for painted cell");

  a_no_done_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !done)
    else $error("result during clearing sweep");

endmodule

`default_nettype wire

// File: rtl/bounded_grid_flood_fill_top.sv
// bounded_grid_flood_fill_top: grid label store with budgeted region fill
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------
//   command  | start in, busy out     | cmd    (bgff_cmd_t)
//   result   | done out, one cycle    | result (bgff_result_t)
//
// a command word is taken at a rising edge with start high and busy low
// write and unused opcodes: done in the cycle after the word; read: done once S_READ has taken the map data
// fill: each painted cell takes a queue pop, a map read, a label write and
//   four neighbour reads pipelined on the single map read port; a skipped
//   cell takes only the queue pop, the map read and the check
// after reset all GRID_WIDTH * GRID_HEIGHT map cells (4096 by default) are
//   swept to zero, one cell a cycle, with busy held high
// the receiver cannot stall: each result word shows for exactly one cycle
`default_nettype none

module bounded_grid_flood_fill_top
  import bgff_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int LABEL_BITS  = LABEL_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire bgff_cmd_t cmd,
  output logic           busy,
  output logic           done,
  output bgff_result_t   result
);

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AB    = $clog2(CELLS);
  // a queue word carries a cell as packed row and column
  localparam int QW    = $clog2(GRID_WIDTH) + $clog2(GRID_HEIGHT);

  // map port
  logic                  map_we;
  logic [AB-1:0]         map_waddr;
  logic [LABEL_BITS-1:0] map_wdata;
  logic [AB-1:0]         map_raddr;
  logic [LABEL_BITS-1:0] map_rdata;

  // queue port
  bgff_qcmd_t            q_cmd;
  bgff_qstat_t           q_stat;
  logic [QW-1:0]         q_wdata;
  logic [QW-1:0]         q_rdata;

  // sequencer: command decode, clearing sweep, fill walk
  bgff_ctrl #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .LABEL_BITS  (LABEL_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .map_we    (map_we),
    .map_waddr (map_waddr),
    .map_wdata (map_wdata),
    .map_raddr (map_raddr),
    .map_rdata (map_rdata),
    .q_cmd     (q_cmd),
    .q_wdata   (q_wdata),
    .q_rdata   (q_rdata),
    .q_stat    (q_stat)
  );

  // cell labels, one read and one write per cycle
  bgff_cell_ram #(
    .DEPTH     (CELLS),
    .DATA_BITS (LABEL_BITS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // breadth-first frontier
  bgff_queue #(
    .DEPTH     (QUEUE_DEPTH),
    .DATA_BITS (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .cmd   (q_cmd),
    .wdata (q_wdata),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

endmodule

`default_nettype wire

// File: tb/sv/bounded_grid_flood_fill_top_tb.sv
// bounded_grid_flood_fill_top_tb: self-checking testbench for the grid flood fill block
`timescale 1ns / 100ps

module bounded_grid_flood_fill_top_tb;
  import bgff_pkg::*;

  // opcode 3 has no meaning in the block, it must answer all zero
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int GRID_W      = GRID_WIDTH_DEF;
  localparam int GRID_H      = GRID_HEIGHT_DEF;
  localparam int GRID_CELLS  = GRID_W * GRID_H;
  localparam int QDEPTH      = QUEUE_DEPTH_DEF;
  localparam int LABEL_W     = LABEL_BITS_DEF;

  // longest sender gap in cycles, and cycles to watch for stray words at the end
  localparam int MAX_GAP     = 20;
  localparam int TAIL_CYCLES = 50;

  // timeout: clearing sweep after reset, then every word a full-budget fill
  // (a bound for each painted cell plus one for each skipped pop, skipped
  // pops bounded by queue traffic) plus the longest sender gap, the whole
  // taken 4x over
  localparam int WORST_WORD_CYCLES = 255 * 8 + QDEPTH * 4 + MAX_GAP + 16;
  localparam int WORD_CAP          = 1200;
  localparam int CYCLE_LIMIT       = 4 * (GRID_CELLS + WORD_CAP * WORST_WORD_CYCLES);

  logic         clk;
  logic         rst   = 1'b1;
  logic         start = 1'b0;
  bgff_cmd_t    cmd   = '0;
  logic         busy;
  logic         done;
  bgff_result_t result;

  bounded_grid_flood_fill_top u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // ---------------------------------------------------------------------
  // predictor state: our own copy of the label map and the fill fifo
  // ---------------------------------------------------------------------
  logic [LABEL_W-1:0] grid_model [GRID_CELLS];
  int                 fill_fifo  [QDEPTH];
  int                 fifo_head;
  int                 fifo_count;
  logic               fill_overflow;

  // result words still owed by the block, oldest first
  bgff_result_t       owed_results [$];
  bgff_result_t       owed;

  // run bookkeeping
  int cycle_count     = 0;
  int error_count     = 0;
  int words_sent      = 0;
  int results_checked = 0;
  int idle_pct        = 0;
  int n_writes        = 0;
  int n_reads         = 0;
  int n_fills         = 0;
  int n_unused        = 0;
  int cells_painted   = 0;
  int widest_fill     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               owed_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // push one cell index, dropping it and flagging overflow when the fifo is full
  function automatic void enqueue_cell(int cell_idx);
    if (fifo_count >= QDEPTH) begin
      fill_overflow = 1'b1;
    end else begin
      fill_fifo[(fifo_head + fifo_count) % QDEPTH] = cell_idx;
      fifo_count++;
    end
  endfunction

  // breadth-first budgeted fill, returns the number of painted passes
  function automatic int flood_region(int seed, logic [LABEL_W-1:0] label, int budget);
    int cell_idx;
    int cx;
    int cy;
    int left;
    fifo_head     = 0;
    fifo_count    = 0;
    fill_overflow = 1'b0;
    left          = budget;
    // the seed goes in whatever its label, it is only tested once popped
    enqueue_cell(seed);
    while (fifo_count != 0) begin
      cell_idx  = fill_fifo[fifo_head];
      fifo_head = (fifo_head + 1) % QDEPTH;
      fifo_count--;
      if (left == 0) break;
      // already labeled cells cost no budget
      if (grid_model[cell_idx] != '0) continue;
      // a zero label leaves the cell at zero but still spends budget
      grid_model[cell_idx] = label;
      cx = cell_idx % GRID_W;
      cy = cell_idx / GRID_W;
      // neighbour order: right, left, down, up
      if (cx + 1 < GRID_W && grid_model[cell_idx + 1] == '0) enqueue_cell(cell_idx + 1);
      if (cx > 0 && grid_model[cell_idx - 1] == '0) enqueue_cell(cell_idx - 1);
      if (cy + 1 < GRID_H && grid_model[cell_idx + GRID_W] == '0)
        enqueue_cell(cell_idx + GRID_W);
      if (cy > 0 && grid_model[cell_idx - GRID_W] == '0) enqueue_cell(cell_idx - GRID_W);
      left--;
    end
    return budget - left;
  endfunction

  // update the model for one accepted word and return the word it must answer
  function automatic bgff_result_t apply_command(bgff_cmd_t w);
    bgff_result_t r;
    int           cell_idx;
    int           painted;
    logic         on_grid;
    r        = '0;
    cell_idx = int'(w.cell_y) * GRID_W + int'(w.cell_x);
    // with the default geometry every 6-bit coordinate lands on the grid
    on_grid  = int'(w.cell_x) < GRID_W && int'(w.cell_y) < GRID_H;
    case (w.opcode)
      OP_WRITE: begin
        n_writes++;
        if (on_grid) grid_model[cell_idx] = LABEL_W'(w.write_value);
      end
      OP_READ: begin
        n_reads++;
        if (on_grid) r.read_value = FIELD_BITS'(grid_model[cell_idx]);
      end
      OP_FILL: begin
        n_fills++;
        if (on_grid) begin
          painted          = flood_region(cell_idx, LABEL_W'(w.region_label),
                                          int'(w.fill_budget));
          r.cells_filled   = painted[FIELD_BITS-1:0];
          r.queue_overflow = fill_overflow;
          cells_painted   += painted;
          if (painted > widest_fill) widest_fill = painted;
        end
      end
      default: begin
        n_unused++;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // result checker: done marks a word for exactly one cycle, reads here see
  // the values the block held just before this edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done) begin
      if (owed_results.size() == 0) begin
        $error("result word with no expectation waiting: %p", result);
        error_count++;
      end else begin
        owed = owed_results.pop_front();
        results_checked++;
        if (result.read_value !== owed.read_value) begin
          $error("read_value: expected %0d, got %0d", owed.read_value, result.read_value);
          error_count++;
        end
        if (result.cells_filled !== owed.cells_filled) begin
          $error("cells_filled: expected %0d, got %0d", owed.cells_filled,
                 result.cells_filled);
          error_count++;
        end
        if (result.queue_overflow !== owed.queue_overflow) begin
          $error("queue_overflow: expected %0d, got %0d", owed.queue_overflow,
                 result.queue_overflow);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------

  function automatic bgff_cmd_t make_word(logic [1:0] op, logic [5:0] x, logic [5:0] y,
                                          logic [7:0] wval, logic [7:0] label,
                                          logic [7:0] budget);
    bgff_cmd_t w;
    w.opcode       = op;
    w.cell_x       = x;
    w.cell_y       = y;
    w.write_value  = wval;
    w.region_label = label;
    w.fill_budget  = budget;
    return w;
  endfunction

  // offer one word, hold it until the block takes it, then predict its answer;
  // start is only lowered on a random gap so it never toggles within a step
  task automatic send_word(input bgff_cmd_t w);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= w;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    owed_results.push_back(apply_command(w));
    words_sent++;
  endtask

  // stop offering words until every owed result has come back
  task automatic wait_drained();
    start <= 1'b0;
    do begin
      @(posedge clk);
    end while (owed_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // corner writes with extreme values, then read them and an untouched cell
  task automatic test_cell_access();
    idle_pct = 28;
    send_word(make_word(OP_WRITE, 6'd0,  6'd0,  8'hff, 8'h00, 8'h00));
    send_word(make_word(OP_WRITE, 6'd63, 6'd0,  8'h01, 8'hff, 8'hff));
    send_word(make_word(OP_WRITE, 6'd0,  6'd63, 8'h80, 8'h00, 8'hff));
    send_word(make_word(OP_WRITE, 6'd63, 6'd63, 8'h55, 8'haa, 8'h00));
    send_word(make_word(OP_WRITE, 6'd20, 6'd30, 8'h00, 8'h11, 8'h22));
    send_word(make_word(OP_READ,  6'd0,  6'd0,  8'h00, 8'h00, 8'h00));
    send_word(make_word(OP_READ,  6'd63, 6'd0,  8'hff, 8'hff, 8'hff));
    send_word(make_word(OP_READ,  6'd0,  6'd63, 8'h00, 8'h00, 8'h00));
    send_word(make_word(OP_READ,  6'd63, 6'd63, 8'h00, 8'h00, 8'h00));
    send_word(make_word(OP_READ,  6'd40, 6'd40, 8'h00, 8'h00, 8'h00));
    wait_drained();
  endtask

  // unused opcode with every field high must change nothing and answer zero
  task automatic test_unused_opcode();
    send_word(make_word(OP_UNUSED, 6'd63, 6'd63, 8'hff, 8'hff, 8'hff));
    send_word(make_word(OP_READ,   6'd63, 6'd63, 8'h00, 8'h00, 8'h00));
    wait_drained();
  endtask

  // zero budget, labeled seed, full budget on open map, zero label, single cell
  task automatic test_fill_special_cases();
    send_word(make_word(OP_FILL, 6'd10, 6'd10, 8'h00, 8'h33, 8'd0));
    send_word(make_word(OP_READ, 6'd10, 6'd10, 8'h00, 8'h00, 8'h00));
    send_word(make_word(OP_FILL, 6'd0,  6'd0,  8'h00, 8'h44, 8'd255));
    send_word(make_word(OP_FILL, 6'd32, 6'd32, 8'h00, 8'hff, 8'd255));
    send_word(make_word(OP_READ, 6'd32, 6'd32, 8'h00, 8'h00, 8'h00));
    send_word(make_word(OP_FILL, 6'd5,  6'd50, 8'h00, 8'h00, 8'd6));
    send_word(make_word(OP_READ, 6'd5,  6'd50, 8'h00, 8'h00, 8'h00));
    send_word(make_word(OP_FILL, 6'd2,  6'd2,  8'h00, 8'h01, 8'd1));
    wait_drained();
  endtask

  // mostly local bursts: clear and wall cells in a small window, fill from a
  // seed inside it and read back; the rest is fully random noise words
  task automatic test_random_mix(input int count, input int pct);
    int        target;
    int        wx;
    int        wy;
    logic [7:0] label;
    logic [7:0] budget;
    idle_pct = pct;
    target   = words_sent + count;
    while (words_sent < target) begin
      if ($urandom_range(99) < 25) begin
        send_word(make_word(2'($urandom_range(3)), 6'($urandom_range(63)),
                            6'($urandom_range(63)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 8'($urandom_range(255))));
      end else begin
        wx = $urandom_range(GRID_W - 8);
        wy = $urandom_range(GRID_H - 8);
        // zeros reopen the window for filling, nonzero values act as walls
        repeat ($urandom_range(4, 12)) begin
          send_word(make_word(OP_WRITE, 6'(wx + $urandom_range(7)),
                              6'(wy + $urandom_range(7)),
                              8'(($urandom_range(99) < 70) ? 0 : $urandom_range(1, 255)),
                              8'($urandom_range(255)), 8'($urandom_range(255))));
        end
        label = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        case ($urandom_range(19))
          0:       budget = 8'd255;
          1, 2:    budget = 8'($urandom_range(41, 254));
          default: budget = 8'($urandom_range(40));
        endcase
        send_word(make_word(OP_FILL, 6'(wx + $urandom_range(7)), 6'(wy + $urandom_range(7)),
                            8'($urandom_range(255)), label, budget));
        repeat ($urandom_range(1, 3)) begin
          send_word(make_word(OP_READ, 6'(wx + $urandom_range(7)),
                              6'(wy + $urandom_range(7)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 8'($urandom_range(255))));
        end
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    foreach (grid_model[i]) grid_model[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // the block sweeps its map after reset with busy high, send_word waits it out
    test_cell_access();
    test_unused_opcode();
    test_fill_special_cases();
    test_random_mix(700, 28);
    // long stretch with back-to-back words
    test_random_mix(300, 0);

    // watch a little longer for any stray result word
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d words: %0d writes, %0d reads, %0d fills, %0d unused opcodes",
             words_sent, n_writes, n_reads, n_fills, n_unused);
    $display("checked %0d results, %0d cells painted in total, widest fill %0d cells",
             results_checked, cells_painted, widest_fill);
    if (error_count == 0 && owed_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/bgff_pkg.sv
rtl/bgff_cell_ram.sv
rtl/bgff_queue.sv
rtl/bgff_ctrl.sv
rtl/bounded_grid_flood_fill_top.sv
tb/sv/bounded_grid_flood_fill_top_tb.sv
